// ===== hdl/psde_pkg.sv =====
// shared types, constants and helper functions of the png stored-deflate encoder
package psde_pkg;

  localparam int DIM_W = 14;
  localparam logic [DIM_W-1:0] MAX_DIMENSION = 14'd16383;
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hffff;
  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454e44;
  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h01;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SIG, ST_IHDR_LEN, ST_IHDR_TYPE, ST_IHDR_W, ST_IHDR_H, ST_IHDR_TAIL,
    ST_IHDR_CRC, ST_IDAT_LEN, ST_IDAT_TYPE, ST_ZHDR, ST_SCAN, ST_BLKHDR, ST_ADLER,
    ST_IDAT_CRC, ST_IEND_LEN, ST_IEND_TYPE, ST_IEND_CRC
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       fin;
  } byte_beat_t;

  typedef struct packed {
    logic crc_en;
    logic crc_init;
    logic adler_en;
    logic adler_init;
  } sum_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] i);
    return w[31 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h89;
      3'd1: r = 8'h50;
      3'd2: r = 8'h4e;
      3'd3: r = 8'h47;
      3'd4: r = 8'h0d;
      3'd5: r = 8'h0a;
      3'd6: r = 8'h1a;
      default: r = 8'h0a;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'd8;
      3'd1: r = 8'd2;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/psde_if.sv =====
// valid/ready channel interfaces for pixels and packed stream words
interface psde_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface psde_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  byte_count;
  logic        item_done;
  logic        frame_done;
  modport source (output valid, out_word, byte_count, item_done, frame_done, input ready);
  modport sink (input valid, out_word, byte_count, item_done, frame_done, output ready);
endinterface

// ===== hdl/psde_checksum.sv =====
// byte-wide crc-32 and adler-32 unit shared by every checksummed stream byte
module psde_checksum (
  input  logic                clk,
  input  logic                rst,
  input  psde_pkg::sum_ctl_t  ctl,
  input  logic [7:0]          data,
  output logic [31:0]         crc,
  output logic [15:0]         adler_low,
  output logic [15:0]         adler_high
);
  logic [31:0] crc_base;
  logic [16:0] low_sum;
  logic [16:0] low_mod;
  logic [16:0] high_sum;
  logic [16:0] high_mod;

  always_comb begin
    crc_base = ctl.crc_init ? psde_pkg::CRC_INIT : crc;
    low_sum  = {1'b0, adler_low} + {9'd0, data};
    low_mod  = (low_sum >= psde_pkg::ADLER_MOD) ? low_sum - psde_pkg::ADLER_MOD : low_sum;
    high_sum = {1'b0, adler_high} + low_mod;
    high_mod = (high_sum >= psde_pkg::ADLER_MOD) ? high_sum - psde_pkg::ADLER_MOD : high_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= psde_pkg::CRC_INIT;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else begin
      if (ctl.crc_en) begin
        crc <= psde_pkg::crc_byte(crc_base, data);
      end
      if (ctl.adler_init) begin
        adler_low  <= 16'd1;
        adler_high <= 16'd0;
      end else if (ctl.adler_en) begin
        adler_low  <= low_mod[15:0];
        adler_high <= high_mod[15:0];
      end
    end
  end
endmodule

// ===== hdl/psde_packer.sv =====
// gathers stream bytes into words of up to four and holds them in an output register
module psde_packer (
  input  logic                  clk,
  input  logic                  rst,
  input  psde_pkg::byte_beat_t  beat,
  output logic                  go,
  psde_word_if.source           out
);
  logic [31:0] acc;
  logic [2:0]  acnt;
  logic        afull;
  logic        alast;
  logic        afin;
  logic        move;

  assign go   = !afull;
  assign move = afull && (!out.valid || out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      acnt      <= 3'd0;
      afull     <= 1'b0;
      out.valid <= 1'b0;
      acc       <= 32'd0;
    end else begin
      if (move) begin
        out.valid      <= 1'b1;
        out.out_word   <= acc;
        out.byte_count <= acnt;
        out.item_done  <= alast;
        out.frame_done <= afin;
        acc            <= 32'd0;
        acnt           <= 3'd0;
        afull          <= 1'b0;
      end else begin
        if (out.ready) begin
          out.valid <= 1'b0;
        end
        if (beat.valid) begin
          acc[31 - 8 * acnt[1:0] -: 8] <= beat.data;
          acnt  <= acnt + 3'd1;
          alast <= beat.last;
          afin  <= beat.fin;
          if (acnt == 3'd3 || beat.last) begin
            afull <= 1'b1;
          end
        end
      end
    end
  end
endmodule

// ===== hdl/png_stored_deflate_encoder_unit.sv =====
// top level: configuration, byte sequencer, checksum unit and word packer
// Each pixel is taken into a register and then walked out one stream byte per
// cycle by the sequencer while the packer is not full, every byte passing
// through the single byte-wide crc and adler unit; pixel ready stays low until
// the sequencer is back at rest. A pixel brings a zero filter byte at a row
// start and its three colour bytes; every full word of a pixel's bytes other
// than its last holds the sequencer while it moves to the output register.
// Where a stored-block header falls the pixel adds its five header bytes, the
// first pixel of a frame adds the signature, IHDR, IDAT and zlib headers and
// the last one the adler, crc and IEND trailer, and the output side may stall.
// Results leave through a one-word register, so the next pixel can be taken
// while the last word of this one waits. Width and height are written only
// between frames; writes during a frame are dropped.
module png_stored_deflate_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  psde_pix_if.sink    pix,
  psde_word_if.source res
);
  psde_pkg::state_t     state, state_next;
  logic [2:0]           idx, idx_next;
  logic [1:0]           pidx, pidx_next;
  logic [13:0]          width, height, col, row;
  logic [7:0]           red_q, green_q, blue_q;
  logic                 in_frame;
  logic [29:0]          total;
  logic [31:0]          idat_len;
  logic [15:0]          block_left;
  logic [29:0]          frame_left;
  logic [15:0]          blk_size;
  logic                 go, emit, accept, pix_end, step_last;
  logic [13:0]          cfg_val;
  psde_pkg::byte_beat_t beat;
  psde_pkg::sum_ctl_t   ctl;
  logic [31:0]          crc;
  logic [15:0]          adler_low, adler_high;
  logic [13:0]          q0;
  logic [16:0]          rem0;
  logic [14:0]          nblk;
  logic [15:0]          row_len;
  logic [29:0]          frame_len;

  assign accept  = pix.valid && pix.ready;
  assign pix.ready = (state == psde_pkg::ST_IDLE);
  assign pix_end = (col + 14'd1 >= width) && (row + 14'd1 >= height);
  assign blk_size = (frame_left > {14'd0, psde_pkg::BLOCK_MAX}) ? psde_pkg::BLOCK_MAX
                                                                 : frame_left[15:0];
  assign cfg_val = (cfg_data == 14'd0) ? 14'd1 : cfg_data;

  // scanline bytes of the frame: (3 * width + 1) * height
  assign row_len   = {1'b0, width, 1'b0} + {2'd0, width} + 16'd1;
  assign frame_len = {14'd0, row_len} * {16'd0, height};

  // block count by 65535 using the 2^16 - 1 folding
  always_comb begin
    q0   = total[29:16];
    rem0 = {1'b0, total[15:0]} + {3'd0, q0};
    if (rem0 >= {1'b0, psde_pkg::BLOCK_MAX}) begin
      nblk = {1'b0, q0} + 15'd1 + {14'd0, (rem0 != {1'b0, psde_pkg::BLOCK_MAX})};
    end else begin
      nblk = {1'b0, q0} + {14'd0, (rem0 != 17'd0)};
    end
  end

  // byte and control outputs of the sequencer
  always_comb begin
    beat = '0;
    ctl  = '0;
    ctl.adler_init = accept && !in_frame;
    unique case (state)
      psde_pkg::ST_SIG:       beat.data = psde_pkg::sig_byte(idx);
      psde_pkg::ST_IHDR_LEN:  beat.data = psde_pkg::byte_sel(psde_pkg::IHDR_LEN, idx[1:0]);
      psde_pkg::ST_IHDR_TYPE: beat.data = psde_pkg::byte_sel(psde_pkg::TYPE_IHDR, idx[1:0]);
      psde_pkg::ST_IHDR_W:    beat.data = psde_pkg::byte_sel({18'd0, width}, idx[1:0]);
      psde_pkg::ST_IHDR_H:    beat.data = psde_pkg::byte_sel({18'd0, height}, idx[1:0]);
      psde_pkg::ST_IHDR_TAIL: beat.data = psde_pkg::tail_byte(idx);
      psde_pkg::ST_IHDR_CRC:  beat.data = psde_pkg::byte_sel(~crc, idx[1:0]);
      psde_pkg::ST_IDAT_LEN:  beat.data = psde_pkg::byte_sel(idat_len, idx[1:0]);
      psde_pkg::ST_IDAT_TYPE: beat.data = psde_pkg::byte_sel(psde_pkg::TYPE_IDAT, idx[1:0]);
      psde_pkg::ST_ZHDR:      beat.data = idx[0] ? psde_pkg::ZLIB_FLG : psde_pkg::ZLIB_CMF;
      psde_pkg::ST_SCAN: begin
        case (pidx)
          2'd0:    beat.data = 8'd0;
          2'd1:    beat.data = red_q;
          2'd2:    beat.data = green_q;
          default: beat.data = blue_q;
        endcase
      end
      psde_pkg::ST_BLKHDR: begin
        case (idx)
          3'd0:    beat.data = {7'd0, ({14'd0, blk_size} == frame_left)};
          3'd1:    beat.data = blk_size[7:0];
          3'd2:    beat.data = blk_size[15:8];
          3'd3:    beat.data = ~blk_size[7:0];
          default: beat.data = ~blk_size[15:8];
        endcase
      end
      psde_pkg::ST_ADLER:     beat.data = psde_pkg::byte_sel({adler_high, adler_low}, idx[1:0]);
      psde_pkg::ST_IDAT_CRC:  beat.data = psde_pkg::byte_sel(~crc, idx[1:0]);
      psde_pkg::ST_IEND_LEN:  beat.data = 8'd0;
      psde_pkg::ST_IEND_TYPE: beat.data = psde_pkg::byte_sel(psde_pkg::TYPE_IEND, idx[1:0]);
      psde_pkg::ST_IEND_CRC:  beat.data = psde_pkg::byte_sel(~crc, idx[1:0]);
      default:                beat.data = 8'd0;
    endcase
    emit = go && (state != psde_pkg::ST_IDLE)
              && !(state == psde_pkg::ST_SCAN && block_left == 16'd0);
    step_last = (state == psde_pkg::ST_SCAN && pidx == 2'd3 && !pix_end)
             || (state == psde_pkg::ST_IEND_CRC && idx == 3'd3);
    beat.valid = emit;
    beat.last  = step_last;
    beat.fin   = (state == psde_pkg::ST_IEND_CRC && idx == 3'd3);
    ctl.crc_en = emit && (state == psde_pkg::ST_IHDR_TYPE || state == psde_pkg::ST_IHDR_W
              || state == psde_pkg::ST_IHDR_H || state == psde_pkg::ST_IHDR_TAIL
              || state == psde_pkg::ST_IDAT_TYPE || state == psde_pkg::ST_ZHDR
              || state == psde_pkg::ST_SCAN || state == psde_pkg::ST_BLKHDR
              || state == psde_pkg::ST_ADLER || state == psde_pkg::ST_IEND_TYPE);
    ctl.crc_init = idx == 3'd0 && (state == psde_pkg::ST_IHDR_TYPE
                || state == psde_pkg::ST_IDAT_TYPE || state == psde_pkg::ST_IEND_TYPE);
    ctl.adler_en = emit && (state == psde_pkg::ST_SCAN);
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    pidx_next  = pidx;
    unique case (state)
      psde_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = in_frame ? psde_pkg::ST_SCAN : psde_pkg::ST_SIG;
          idx_next   = 3'd0;
          pidx_next  = (col == 14'd0) ? 2'd0 : 2'd1;
        end
      end
      psde_pkg::ST_SCAN: begin
        if (go && block_left == 16'd0) begin
          state_next = psde_pkg::ST_BLKHDR;
          idx_next   = 3'd0;
        end else if (emit) begin
          if (pidx == 2'd3) begin
            state_next = pix_end ? psde_pkg::ST_ADLER : psde_pkg::ST_IDLE;
            idx_next   = 3'd0;
          end else begin
            pidx_next = pidx + 2'd1;
          end
        end
      end
      default: begin
        if (emit) begin
          idx_next = idx + 3'd1;
          unique case (state)
            psde_pkg::ST_SIG:
              if (idx == 3'd7) begin state_next = psde_pkg::ST_IHDR_LEN; idx_next = 3'd0; end
            psde_pkg::ST_IHDR_LEN:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IHDR_TYPE; idx_next = 3'd0; end
            psde_pkg::ST_IHDR_TYPE:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IHDR_W; idx_next = 3'd0; end
            psde_pkg::ST_IHDR_W:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IHDR_H; idx_next = 3'd0; end
            psde_pkg::ST_IHDR_H:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IHDR_TAIL; idx_next = 3'd0; end
            psde_pkg::ST_IHDR_TAIL:
              if (idx == 3'd4) begin state_next = psde_pkg::ST_IHDR_CRC; idx_next = 3'd0; end
            psde_pkg::ST_IHDR_CRC:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IDAT_LEN; idx_next = 3'd0; end
            psde_pkg::ST_IDAT_LEN:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IDAT_TYPE; idx_next = 3'd0; end
            psde_pkg::ST_IDAT_TYPE:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_ZHDR; idx_next = 3'd0; end
            psde_pkg::ST_ZHDR:
              if (idx == 3'd1) begin state_next = psde_pkg::ST_SCAN; idx_next = 3'd0; end
            psde_pkg::ST_BLKHDR:
              if (idx == 3'd4) begin state_next = psde_pkg::ST_SCAN; idx_next = 3'd0; end
            psde_pkg::ST_ADLER:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IDAT_CRC; idx_next = 3'd0; end
            psde_pkg::ST_IDAT_CRC:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IEND_LEN; idx_next = 3'd0; end
            psde_pkg::ST_IEND_LEN:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IEND_TYPE; idx_next = 3'd0; end
            psde_pkg::ST_IEND_TYPE:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IEND_CRC; idx_next = 3'd0; end
            psde_pkg::ST_IEND_CRC:
              if (idx == 3'd3) begin state_next = psde_pkg::ST_IDLE; idx_next = 3'd0; end
            default: state_next = psde_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= psde_pkg::ST_IDLE;
      idx        <= 3'd0;
      pidx       <= 2'd0;
      width      <= 14'd1;
      height     <= 14'd1;
      in_frame   <= 1'b0;
      col        <= 14'd0;
      row        <= 14'd0;
      block_left <= 16'd0;
      frame_left <= 30'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pidx  <= pidx_next;
      if (cfg_wr_en && !in_frame) begin
        if (cfg_index == psde_pkg::CFG_WIDTH) width <= cfg_val;
        if (cfg_index == psde_pkg::CFG_HEIGHT) height <= cfg_val;
      end
      if (accept) begin
        red_q   <= pix.red;
        green_q <= pix.green;
        blue_q  <= pix.blue;
        if (!in_frame) begin
          in_frame   <= 1'b1;
          block_left <= 16'd0;
          frame_left <= frame_len;
          total      <= frame_len;
        end
      end
      if (emit && state == psde_pkg::ST_BLKHDR && idx == 3'd4) begin
        block_left <= blk_size;
      end
      if (emit && state == psde_pkg::ST_SCAN) begin
        block_left <= block_left - 16'd1;
        if (frame_left != 30'd0) frame_left <= frame_left - 30'd1;
        if (pidx == 2'd3) begin
          if (col + 14'd1 >= width) begin
            col <= 14'd0;
            row <= (row + 14'd1 >= height) ? 14'd0 : row + 14'd1;
          end else begin
            col <= col + 14'd1;
          end
        end
      end
      if (emit && state == psde_pkg::ST_IEND_CRC && idx == 3'd3) begin
        in_frame <= 1'b0;
      end
    end
  end

  // idat length is registered from total; read only after the signature and ihdr bytes have gone out
  always_ff @(posedge clk) begin
    idat_len <= 32'd6 + ({17'd0, nblk} * 32'd5) + {2'd0, total};
  end

  psde_checksum u_sum (
    .clk(clk), .rst(rst), .ctl(ctl), .data(beat.data),
    .crc(crc), .adler_low(adler_low), .adler_high(adler_high)
  );

  psde_packer u_pack (
    .clk(clk), .rst(rst), .beat(beat), .go(go), .out(res)
  );
endmodule

// ===== hdl/psde_checker.sv =====
// port-level checks of the encoder, bound to the top level
module psde_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_count,
  input logic        item_done,
  input logic        frame_done
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 3'd0 && byte_count <= 3'd4)) else $error("bad byte count");
  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> item_done) else $error("frame end without item end");
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count != 3'd4 |-> item_done) else $error("short word mid item");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready while pixel in work");
endmodule

bind png_stored_deflate_encoder_unit psde_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(pix.valid), .in_ready(pix.ready),
  .out_valid(res.valid), .out_ready(res.ready), .byte_count(res.byte_count),
  .item_done(res.item_done), .frame_done(res.frame_done)
);

// ===== tb/tb_png_stored_deflate_encoder_unit.sv =====
// testbench for the png stored-deflate encoder: random pixels, byte-exact stream prediction
`timescale 1ns / 1ps

module tb_png_stored_deflate_encoder_unit;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        idone;
    logic        fdone;
  } stream_word_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [13:0] cfg_data;

  psde_pix_if  pix ();
  psde_word_if res ();

  png_stored_deflate_encoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .res       (res)
  );

  // predictor state
  logic [13:0] img_w, img_h;
  logic        in_frame;
  logic [13:0] col, row;
  logic [31:0] blk_left, frm_left;
  logic [31:0] crc;
  logic [15:0] ad_lo, ad_hi;
  logic [7:0]  stream_bytes[$];

  pixel_t       pixel_q[$];
  stream_word_t expected_words[$];

  int src_idle, snk_idle;
  int mismatches, words_seen, pixels_taken, frames_done, stall_cycles;
  bit pix_took, hold_go, hold_done;
  int hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = (r >> 1) ^ (32'hedb88320 & {32{r[0]}});
    return r;
  endfunction

  function automatic void emit(logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  function automatic void emit_crc(logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
    crc = crc_step(crc, b);
  endfunction

  function automatic void emit32(logic [31:0] v, bit with_crc);
    for (int i = 3; i >= 0; i--) begin
      if (with_crc) emit_crc(v[8*i +: 8]);
      else emit(v[8*i +: 8]);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    logic [31:0] size, inv;
    if (blk_left == 0) begin
      size = (frm_left > 32'd65535) ? 32'd65535 : frm_left;
      inv = ~size & 32'hffff;
      emit_crc((size == frm_left) ? 8'd1 : 8'd0);
      emit_crc(size[7:0]);
      emit_crc(size[15:8]);
      emit_crc(inv[7:0]);
      emit_crc(inv[15:8]);
      blk_left = size;
    end
    emit_crc(b);
    ad_lo = 16'((32'(ad_lo) + b) % 65521);
    ad_hi = 16'((32'(ad_hi) + ad_lo) % 65521);
    if (blk_left != 0) blk_left--;
    if (frm_left != 0) frm_left--;
  endfunction

  function automatic void open_frame();
    logic [31:0] total, blocks;
    logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a};
    logic [7:0] tail[5] = '{8'd8, 8'd2, 8'd0, 8'd0, 8'd0};
    total = (3 * 32'(img_w) + 1) * 32'(img_h);
    blocks = (total + 32'd65534) / 32'd65535;
    foreach (sig[i]) emit(sig[i]);
    emit32(32'd13, 0);
    crc = 32'hffffffff;
    emit32(psde_pkg::TYPE_IHDR, 1);
    emit32(32'(img_w), 1);
    emit32(32'(img_h), 1);
    foreach (tail[i]) emit_crc(tail[i]);
    emit32(crc ^ 32'hffffffff, 0);
    emit32(2 + 5 * blocks + total + 4, 0);
    crc = 32'hffffffff;
    emit32(psde_pkg::TYPE_IDAT, 1);
    emit_crc(psde_pkg::ZLIB_CMF);
    emit_crc(psde_pkg::ZLIB_FLG);
    ad_lo = 16'd1;
    ad_hi = 16'd0;
    frm_left = total;
    blk_left = 0;
    col = 0;
    row = 0;
    in_frame = 1'b1;
  endfunction

  function automatic void close_frame();
    emit32({ad_hi, ad_lo}, 1);
    emit32(crc ^ 32'hffffffff, 0);
    emit32(32'd0, 0);
    crc = 32'hffffffff;
    emit32(psde_pkg::TYPE_IEND, 1);
    emit32(crc ^ 32'hffffffff, 0);
    crc = 32'hffffffff;
    in_frame = 1'b0;
  endfunction

  // works out every stream word one pixel brings out
  function automatic void predict_pixel(pixel_t p);
    bit ended;
    int n;
    stream_word_t sw;
    ended = 0;
    stream_bytes.delete();
    if (!in_frame) open_frame();
    if (col == 0) scan_byte(8'd0);
    scan_byte(p.r);
    scan_byte(p.g);
    scan_byte(p.b);
    col++;
    if (col >= img_w) begin
      col = 0;
      row++;
      if (row >= img_h) begin
        row = 0;
        close_frame();
        ended = 1;
      end
    end
    n = (stream_bytes.size() + 3) / 4;
    for (int k = 0; k < n; k++) begin
      sw.word = '0;
      sw.cnt = 0;
      for (int j = 0; j < 4 && 4 * k + j < stream_bytes.size(); j++) begin
        sw.word[31 - 8 * j -: 8] = stream_bytes[4 * k + j];
        sw.cnt++;
      end
      sw.idone = (k == n - 1);
      sw.fdone = ended && (k == n - 1);
      expected_words.insert(expected_words.size(), sw);
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    pix_took = !rst && pix.valid && pix.ready;
    if (pix_took) begin
      predict_pixel('{pix.red, pix.green, pix.blue});
      pixels_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_took) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        pixel_t p;
        p = pixel_q.pop_front();
        pix.valid <= 1'b1;
        pix.red <= p.r;
        pix.green <= p.g;
        pix.blue <= p.b;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      words_seen++;
      if (res.frame_done) frames_done++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: word %h count %0d", res.out_word, res.byte_count);
      end else begin
        stream_word_t e;
        e = expected_words.pop_front();
        if (res.out_word !== e.word || res.byte_count !== e.cnt ||
            res.item_done !== e.idone || res.frame_done !== e.fdone) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b", words_seen,
                     e.word, e.cnt, e.idone, e.fdone, res.out_word, res.byte_count,
                     res.item_done, res.frame_done);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d beats outstanding", expected_words.size());
      $display("png_stored_deflate_encoder_unit verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pixel_q.size() != 0 || pix.valid !== 1'b0) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_dim(logic idx, logic [13:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == psde_pkg::CFG_WIDTH) img_w = (val == 0) ? 14'd1 : val;
    else img_h = (val == 0) ? 14'd1 : val;
  endtask

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic random_frames(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      write_dim(psde_pkg::CFG_WIDTH, 14'($urandom_range(8, 1)));
      write_dim(psde_pkg::CFG_HEIGHT, 14'($urandom_range(5, 1)));
      for (int i = 0; i < img_w * img_h; i++)
        push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      sent += img_w * img_h;
      drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = psde_pkg::CFG_WIDTH;
    cfg_data = '0;
    img_w = 14'd1;
    img_h = 14'd1;
    in_frame = 1'b0;
    col = 0;
    row = 0;
    blk_left = 0;
    frm_left = 0;
    crc = 32'hffffffff;
    ad_lo = 16'd1;
    ad_hi = 16'd0;
    src_idle = 26;
    snk_idle = 70;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-pixel frame at reset dimensions, then zero written as width and height
    push_pixel(8'h00, 8'h00, 8'h00);
    drain();
    write_dim(psde_pkg::CFG_WIDTH, 14'd0);
    write_dim(psde_pkg::CFG_HEIGHT, 14'd0);
    push_pixel(8'hff, 8'hff, 8'hff);
    drain();
    write_dim(psde_pkg::CFG_WIDTH, 14'd3);
    write_dim(psde_pkg::CFG_HEIGHT, 14'd2);
    push_pixel(8'hff, 8'h00, 8'haa);
    push_pixel(8'h55, 8'hff, 8'h00);
    push_pixel(8'h01, 8'h80, 8'hfe);
    push_pixel(8'h7f, 8'h00, 8'hff);
    push_pixel(8'haa, 8'h55, 8'h01);
    push_pixel(8'h00, 8'hff, 8'h80);
    drain();

    random_frames(100);
    src_idle = 70;
    snk_idle = 26;
    random_frames(55);
    src_idle = 0;
    snk_idle = 0;
    hold_go = 1;
    random_frames(60);

    // opening of the largest frame, whose idat length spans many stored blocks
    write_dim(psde_pkg::CFG_WIDTH, 14'd16383);
    write_dim(psde_pkg::CFG_HEIGHT, 14'd16383);
    for (int i = 0; i < 8; i++)
      push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    drain();

    $display("pixels %0d, stream beats %0d, frames closed %0d, mismatches %0d",
             pixels_taken, words_seen, frames_done, mismatches);
    $display("covered 1x1 to 8x5 frames, zero dimensions, a long output hold-off and");
    $display("the headers of a 16383 by 16383 frame");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("png_stored_deflate_encoder_unit verification clean");
    end else begin
      $display("png_stored_deflate_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
